// ----- rtl/mvm_pkg.sv -----
// Shared widths, register indexes and function codes of the matrix-vector multiply unit.
package mvm_pkg;

   localparam int OPERAND_W   = 32;
   localparam int PRODUCT_W   = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 5;
   localparam int FRAC_BITS   = 16;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 5'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROWS_USED = 4'd0,
      CSR_COLS_USED = 4'd1
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_VECTOR = 1'b1
   } func_type;

endpackage

// ----- rtl/mvm_if.sv -----
// Valid/ready channel interfaces for requests, responses and register writes.
interface mvm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic signed [mvm_pkg::OPERAND_W-1:0] operand;
   logic                             vec_end;

   modport source (output valid, output func, output operand, output vec_end, input ready);
   modport sink (input valid, input func, input operand, input vec_end, output ready);
endinterface

interface mvm_rsp_if #(parameter int ROW_W = 4);
   logic                             valid;
   logic                             ready;
   logic [ROW_W-1:0]                 row_index;
   logic signed [mvm_pkg::PRODUCT_W-1:0] product;
   logic                             saturated;
   logic                             mismatch;
   logic                             final_row;

   modport source (output valid, output row_index, output product, output saturated,
                   output mismatch, output final_row, input ready);
   modport sink (input valid, input row_index, input product, input saturated,
                 input mismatch, input final_row, output ready);
endinterface

interface mvm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mvm_pkg::CSR_INDEX_W-1:0]   index;
   logic [mvm_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/matrix_vector_multiply_unit.sv -----
// Dense matrix-vector multiply unit on signed Q16.16 values held in on-chip memories.
//
// A matrix beat (func=0) writes the next row-major entry; the first matrix beat after a
// register write first recomputes the row and column of the load position with a
// bit-serial divider. A vector beat (func=1) is taken without leaving the idle state.
// The marked last vector beat starts the multiply: for each row the sequencer reads one
// matrix entry and one vector element per cycle from the two memories, runs them through
// a registered multiplier and accumulator, rounds and clips. A length mismatch gives one
// error beat. The response interface must be built with ROW_W = $clog2(MAX_DIM). The
// memories have no reset; only entries already loaded may be used by a multiply.
module matrix_vector_multiply_unit #(
   parameter int MAX_DIM     = 16,
   parameter int VALUE_WIDTH = 32
) (
   input logic          clock,
   input logic          reset,
   mvm_req_if.sink      req_chan,
   mvm_rsp_if.source    rsp_chan,
   mvm_csr_if.sink      csr_chan
);

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int CNT_W  = $clog2(MAX_DIM + 2);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(DEPTH + 1);
   localparam int STEP_W = $clog2(POS_W + 1);
   localparam int PROD_W = 2 * VALUE_WIDTH;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (mvm_pkg::FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] VMAX =
      {{(ACC_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] VMIN = ~VMAX;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DIV   = 8'b0000_0010,
      S_LOAD  = 8'b0000_0100,
      S_MAC   = 8'b0000_1000,
      S_DRAIN = 8'b0001_0000,
      S_ROUND = 8'b0010_0000,
      S_EMIT  = 8'b0100_0000,
      S_ERR   = 8'b1000_0000
   } state_type;

   function automatic logic [CNT_W-1:0] clamp_dim(input logic [mvm_pkg::CSR_DATA_W-1:0] v);
      int t;
      t = int'(v);
      if (t < 1) t = 1;
      else if (t > MAX_DIM) t = MAX_DIM;
      return CNT_W'(t);
   endfunction

   // Control state.
   state_type                       state_ff, state_in;
   logic [mvm_pkg::CSR_DATA_W-1:0]  rows_used_ff, rows_used_in;
   logic [mvm_pkg::CSR_DATA_W-1:0]  cols_used_ff, cols_used_in;
   logic                            recalc_ff, recalc_in;
   logic [POS_W-1:0]                load_pos_ff, load_pos_in;
   logic [DIM_W-1:0]                load_row_ff, load_row_in;
   logic [DIM_W-1:0]                load_col_ff, load_col_in;
   logic [CNT_W-1:0]                vec_cnt_ff, vec_cnt_in;
   logic [DIM_W-1:0]                mac_row_ff, mac_row_in;
   logic [DIM_W-1:0]                mac_col_ff, mac_col_in;
   logic [STEP_W-1:0]               div_cnt_ff, div_cnt_in;
   logic                            s1_valid_ff, s1_first_ff, s1_last_ff;
   logic                            s2_valid_ff, s2_first_ff, s2_last_ff;
   logic                            acc_done_ff;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [VALUE_WIDTH-1:0]   op_ff, op_in;
   logic [POS_W-1:0]                div_quo_ff, div_quo_in;
   logic [CNT_W-1:0]                div_rem_ff, div_rem_in;
   logic signed [VALUE_WIDTH-1:0]   m_rd_ff, v_rd_ff;
   logic signed [PROD_W-1:0]        prod_ff;
   logic signed [ACC_W-1:0]         acc_ff;
   logic signed [ACC_W-1:0]         round_ff;
   logic [DIM_W-1:0]                out_row_ff, out_row_in;
   logic signed [mvm_pkg::PRODUCT_W-1:0] out_prod_ff, out_prod_in;
   logic                            out_sat_ff, out_sat_in;
   logic                            out_mis_ff, out_mis_in;
   logic                            out_fin_ff, out_fin_in;

   logic signed [VALUE_WIDTH-1:0]   matrix_mem [DEPTH];
   logic signed [VALUE_WIDTH-1:0]   vector_mem [MAX_DIM];

   logic [CNT_W-1:0]                rows_c, cols_c;
   logic [POS_W-1:0]                total;
   logic [POS_W-1:0]                eff_pos;
   logic [POS_W-1:0]                pos_next;
   logic [CNT_W-1:0]                vec_cnt_next;
   logic                            mat_we, vec_we;
   logic [ADDR_W-1:0]               load_addr, mac_addr;
   logic                            mac_last_col, mac_last_row;
   logic                            slot_free;
   logic [CNT_W:0]                  rem_shift;
   logic                            rem_ge;
   logic [CNT_W-1:0]                div_rem_next;
   logic [POS_W-1:0]                div_quo_next;
   logic signed [VALUE_WIDTH-1:0]   req_val;
   logic signed [VALUE_WIDTH-1:0]   sat_val;
   logic                            sat_flag;
   logic signed [ACC_W-1:0]         acc_half;

   assign rows_c  = clamp_dim(rows_used_ff);
   assign cols_c  = clamp_dim(cols_used_ff);
   assign total   = POS_W'(rows_c) * POS_W'(cols_c);
   // A register change can leave the load position past the new matrix size.
   assign eff_pos = (load_pos_ff >= total) ? '0 : load_pos_ff;
   assign pos_next = load_pos_ff + POS_W'(1);
   assign req_val = req_chan.operand[VALUE_WIDTH-1:0];
   assign vec_cnt_next = (vec_cnt_ff <= CNT_W'(MAX_DIM)) ? vec_cnt_ff + CNT_W'(1) : vec_cnt_ff;

   assign load_addr = ADDR_W'(load_row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(load_col_ff);
   assign mac_addr  = ADDR_W'(mac_row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(mac_col_ff);
   assign mac_last_col = (CNT_W'(mac_col_ff) + CNT_W'(1)) == cols_c;
   assign mac_last_row = (CNT_W'(mac_row_ff) + CNT_W'(1)) == rows_c;

   assign rem_shift    = {div_rem_ff, div_quo_ff[POS_W-1]};
   assign rem_ge       = rem_shift >= {1'b0, cols_c};
   assign div_rem_next = rem_ge ? CNT_W'(rem_shift - {1'b0, cols_c}) : CNT_W'(rem_shift);
   assign div_quo_next = {div_quo_ff[POS_W-2:0], rem_ge};

   assign acc_half = acc_ff + HALF;

   always_comb begin
      sat_flag = 1'b0;
      sat_val  = round_ff[VALUE_WIDTH-1:0];
      if (round_ff > VMAX) begin
         sat_flag = 1'b1;
         sat_val  = VMAX[VALUE_WIDTH-1:0];
      end else if (round_ff < VMIN) begin
         sat_flag = 1'b1;
         sat_val  = VMIN[VALUE_WIDTH-1:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      recalc_in    = recalc_ff;
      load_pos_in  = load_pos_ff;
      load_row_in  = load_row_ff;
      load_col_in  = load_col_ff;
      vec_cnt_in   = vec_cnt_ff;
      mac_row_in   = mac_row_ff;
      mac_col_in   = mac_col_ff;
      div_cnt_in   = div_cnt_ff;
      div_quo_in   = div_quo_ff;
      div_rem_in   = div_rem_ff;
      op_in        = op_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_chan.ready) ? 1'b0 : rsp_valid_ff;
      out_row_in   = out_row_ff;
      out_prod_in  = out_prod_ff;
      out_sat_in   = out_sat_ff;
      out_mis_in   = out_mis_ff;
      out_fin_in   = out_fin_ff;
      mat_we       = 1'b0;
      vec_we       = 1'b0;

      if (csr_chan.valid) begin
         recalc_in = 1'b1;
         if (csr_chan.index == mvm_pkg::CSR_ROWS_USED) rows_used_in = csr_chan.data;
         if (csr_chan.index == mvm_pkg::CSR_COLS_USED) cols_used_in = csr_chan.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in = req_val;
               if (req_chan.func == mvm_pkg::FUNC_LOAD) begin
                  if (recalc_ff) begin
                     load_pos_in = eff_pos;
                     div_quo_in  = eff_pos;
                     div_rem_in  = '0;
                     div_cnt_in  = STEP_W'(POS_W);
                     state_in    = S_DIV;
                  end else begin
                     state_in = S_LOAD;
                  end
               end else begin
                  vec_we = vec_cnt_ff < CNT_W'(MAX_DIM);
                  if (req_chan.vec_end) begin
                     vec_cnt_in = '0;
                     if (vec_cnt_next != cols_c) begin
                        state_in = S_ERR;
                     end else begin
                        mac_row_in = '0;
                        mac_col_in = '0;
                        state_in   = S_MAC;
                     end
                  end else begin
                     vec_cnt_in = vec_cnt_next;
                  end
               end
            end
         end
         S_DIV: begin
            // Restoring division of the load position by the column count.
            div_quo_in = div_quo_next;
            div_rem_in = div_rem_next;
            div_cnt_in = div_cnt_ff - STEP_W'(1);
            if (div_cnt_ff == STEP_W'(1)) begin
               load_row_in = DIM_W'(div_quo_next);
               load_col_in = DIM_W'(div_rem_next);
               recalc_in   = 1'b0;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            mat_we = 1'b1;
            if (pos_next >= total) begin
               load_pos_in = '0;
               load_row_in = '0;
               load_col_in = '0;
            end else begin
               load_pos_in = pos_next;
               if ((CNT_W'(load_col_ff) + CNT_W'(1)) == cols_c) begin
                  load_col_in = '0;
                  load_row_in = load_row_ff + DIM_W'(1);
               end else begin
                  load_col_in = load_col_ff + DIM_W'(1);
               end
            end
            state_in = S_IDLE;
         end
         S_MAC: begin
            if (mac_last_col) state_in = S_DRAIN;
            else mac_col_in = mac_col_ff + DIM_W'(1);
         end
         S_DRAIN: begin
            if (acc_done_ff) state_in = S_ROUND;
         end
         S_ROUND: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_row_in   = mac_row_ff;
               out_prod_in  = mvm_pkg::PRODUCT_W'(sat_val);
               out_sat_in   = sat_flag;
               out_mis_in   = 1'b0;
               out_fin_in   = mac_last_row;
               if (mac_last_row) begin
                  state_in = S_IDLE;
               end else begin
                  mac_row_in = mac_row_ff + DIM_W'(1);
                  mac_col_in = '0;
                  state_in   = S_MAC;
               end
            end
         end
         S_ERR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_row_in   = '0;
               out_prod_in  = '0;
               out_sat_in   = 1'b0;
               out_mis_in   = 1'b1;
               out_fin_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_used_ff <= mvm_pkg::DIM_RESET;
         cols_used_ff <= mvm_pkg::DIM_RESET;
         recalc_ff    <= 1'b0;
         load_pos_ff  <= '0;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         vec_cnt_ff   <= '0;
         mac_row_ff   <= '0;
         mac_col_ff   <= '0;
         div_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s1_first_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_first_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         recalc_ff    <= recalc_in;
         load_pos_ff  <= load_pos_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         vec_cnt_ff   <= vec_cnt_in;
         mac_row_ff   <= mac_row_in;
         mac_col_ff   <= mac_col_in;
         div_cnt_ff   <= div_cnt_in;
         s1_valid_ff  <= state_ff == S_MAC;
         s1_first_ff  <= mac_col_ff == '0;
         s1_last_ff   <= mac_last_col;
         s2_valid_ff  <= s1_valid_ff;
         s2_first_ff  <= s1_first_ff;
         s2_last_ff   <= s1_last_ff;
         acc_done_ff  <= s2_valid_ff && s2_last_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      prod_ff     <= m_rd_ff * v_rd_ff;
      if (s2_valid_ff) begin
         acc_ff <= (s2_first_ff ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
      end
      // Round to nearest with ties toward plus infinity.
      if (state_ff == S_ROUND) round_ff <= acc_half >>> mvm_pkg::FRAC_BITS;
      out_row_ff  <= out_row_in;
      out_prod_ff <= out_prod_in;
      out_sat_ff  <= out_sat_in;
      out_mis_ff  <= out_mis_in;
      out_fin_ff  <= out_fin_in;
   end

   // Loads and the multiply walk never overlap, so the memories need no forwarding.
   always_ff @(posedge clock) begin
      if (mat_we) matrix_mem[load_addr] <= op_ff;
      m_rd_ff <= matrix_mem[mac_addr];
   end

   always_ff @(posedge clock) begin
      if (vec_we) vector_mem[vec_cnt_ff[DIM_W-1:0]] <= req_val;
      v_rd_ff <= vector_mem[mac_col_ff];
   end

   assign req_chan.ready     = state_ff == S_IDLE;
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.row_index = out_row_ff;
   assign rsp_chan.product   = out_prod_ff;
   assign rsp_chan.saturated = out_sat_ff;
   assign rsp_chan.mismatch  = out_mis_ff;
   assign rsp_chan.final_row = out_fin_ff;

endmodule

// ----- sim/matrix_vector_multiply_unit_tb.sv -----
// Self-checking testbench for the matrix-vector multiply unit with its own row-product predictor.
module matrix_vector_multiply_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM      = 16;
   localparam int RANDOM_BEATS = 280;
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_CYCLES  = 40;
   localparam int TIMEOUT_NS    = 4_000_000;
   localparam int REPORT_LIMIT  = 10;

   // Short names for the codes used in the stimulus table and the drivers.
   localparam mvm_pkg::csr_index_type REG_ROWS = mvm_pkg::CSR_ROWS_USED;
   localparam mvm_pkg::csr_index_type REG_COLS = mvm_pkg::CSR_COLS_USED;
   localparam mvm_pkg::func_type      F_LOAD   = mvm_pkg::FUNC_LOAD;
   localparam mvm_pkg::func_type      F_VEC    = mvm_pkg::FUNC_VECTOR;

   typedef struct packed {
      logic [3:0]                           row;
      logic signed [mvm_pkg::PRODUCT_W-1:0] product;
      logic                                 saturated;
      logic                                 mismatch;
      logic                                 final_row;
   } rsp_beat_type;

   typedef enum logic {
      STEP_CSR,
      STEP_BEAT
   } step_kind_type;

   typedef struct {
      step_kind_type                   kind;
      mvm_pkg::csr_index_type          reg_index;
      logic [mvm_pkg::CSR_DATA_W-1:0]  reg_value;
      mvm_pkg::func_type               func;
      logic [mvm_pkg::OPERAND_W-1:0]   operand;
      logic                            vec_end;
      bit                              typed;
      rsp_beat_type                    want;
   } dir_step_type;

   localparam rsp_beat_type NO_BEAT       = '0;
   localparam rsp_beat_type MISMATCH_BEAT = '{4'd0, 32'sd0, 1'b0, 1'b1, 1'b1};
   localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
   localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

   logic clock;
   logic reset;

   mvm_req_if                req_bus ();
   mvm_rsp_if #(.ROW_W(4))   rsp_bus ();
   mvm_csr_if                csr_bus ();

   matrix_vector_multiply_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state, mirrored from what the block has accepted so far.
   logic signed [mvm_pkg::OPERAND_W-1:0] matrix_entry [MAX_DIM*MAX_DIM];
   bit                                   entry_loaded [MAX_DIM*MAX_DIM];
   logic signed [mvm_pkg::OPERAND_W-1:0] vector_elem [MAX_DIM];
   int                                   load_slot;
   int                                   elem_count;
   logic [mvm_pkg::CSR_DATA_W-1:0]       rows_reg;
   logic [mvm_pkg::CSR_DATA_W-1:0]       cols_reg;

   rsp_beat_type computed_beats [$];
   rsp_beat_type expected_beats [$];

   int  fail_count;
   int  beats_sent;
   int  reg_writes;
   int  product_beats;
   int  length_errors;
   bit  tx_burst;

   // The steps at the end use a 2x2 matrix; the first two run at the reset size, 16x16, and those between at 1x1.
   dir_step_type directed_steps [24] = '{
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h0001_0000, 1'b1, 1'b1, MISMATCH_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_LOAD, 32'h1234_5678, 1'b1, 1'b0, NO_BEAT},
      '{STEP_CSR,  REG_ROWS, 5'd0,  F_LOAD, 32'h0,         1'b0, 1'b0, NO_BEAT},
      '{STEP_CSR,  REG_COLS, 5'd0,  F_LOAD, 32'h0,         1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_LOAD, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h7FFF_FFFF, 1'b1, 1'b1,
        '{4'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1}},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h8000_0000, 1'b1, 1'b1,
        '{4'd0, 32'h8000_0000, 1'b1, 1'b0, 1'b1}},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_LOAD, 32'h8000_0000, 1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h8000_0000, 1'b1, 1'b1,
        '{4'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1}},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h0000_0000, 1'b1, 1'b1,
        '{4'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_LOAD, 32'h0000_0001, 1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h0000_8000, 1'b1, 1'b1,
        '{4'd0, 32'h0000_0001, 1'b0, 1'b0, 1'b1}},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'hFFFF_8000, 1'b1, 1'b1,
        '{4'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'hFFFF_7FFF, 1'b1, 1'b1,
        '{4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1}},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h0001_0000, 1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h0001_0000, 1'b1, 1'b1, MISMATCH_BEAT},
      '{STEP_CSR,  REG_COLS, 5'd2,  F_LOAD, 32'h0,         1'b0, 1'b0, NO_BEAT},
      '{STEP_CSR,  REG_ROWS, 5'd2,  F_LOAD, 32'h0,         1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_LOAD, 32'h0001_8000, 1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_LOAD, 32'hFFFF_0000, 1'b1, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_LOAD, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_LOAD, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h0002_0000, 1'b0, 1'b0, NO_BEAT},
      '{STEP_BEAT, REG_ROWS, 5'd0,  F_VEC,  32'h0003_0000, 1'b1, 1'b0, NO_BEAT}
   };

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int dim_of(logic [mvm_pkg::CSR_DATA_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_DIM) return MAX_DIM;
      return int'(value);
   endfunction

   // Register value for a wanted size, sometimes through the out-of-range aliases.
   function automatic logic [mvm_pkg::CSR_DATA_W-1:0] encode_dim(int size);
      if (size == 1 && $urandom_range(0, 3) == 0) return '0;
      if (size == MAX_DIM && $urandom_range(0, 1) == 1)
         return mvm_pkg::CSR_DATA_W'($urandom_range(17, 31));
      return mvm_pkg::CSR_DATA_W'(size);
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [mvm_pkg::OPERAND_W-1:0] rand_operand();
      logic [mvm_pkg::OPERAND_W-1:0] value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = $urandom;
         4, 5, 6:    value = $urandom_range(0, 32'h0004_0000);
         7: begin
            case ($urandom_range(0, 3))
               0: value = 32'h7FFF_FFFF;
               1: value = 32'h8000_0000;
               2: value = 32'hFFFF_FFFF;
               default: value = '0;
            endcase
         end
         default: value = $urandom_range(0, 32'h0010_0000);
      endcase
      if ($urandom_range(0, 2) == 0) value = -value;
      return value;
   endfunction

   task automatic predict_beat(input mvm_pkg::func_type func,
                               input logic signed [mvm_pkg::OPERAND_W-1:0] value,
                               input logic last);
      int rows;
      int cols;
      int total;
      int r;
      int c;
      logic signed [71:0] sum;
      logic signed [71:0] entry_ext;
      logic signed [71:0] elem_ext;
      logic signed [71:0] rounded;
      rsp_beat_type beat;
      rows = dim_of(rows_reg);
      cols = dim_of(cols_reg);
      computed_beats.delete();
      if (func == F_LOAD) begin
         total = rows * cols;
         if (load_slot >= total) load_slot = 0;
         r = load_slot / cols;
         c = load_slot % cols;
         matrix_entry[r*MAX_DIM + c] = value;
         entry_loaded[r*MAX_DIM + c] = 1'b1;
         load_slot++;
         if (load_slot >= total) load_slot = 0;
         return;
      end
      if (elem_count < MAX_DIM) vector_elem[elem_count] = value;
      if (elem_count <= MAX_DIM) elem_count++;
      if (!last) return;
      if (elem_count != cols) begin
         elem_count = 0;
         computed_beats.push_back(MISMATCH_BEAT);
         length_errors++;
         return;
      end
      elem_count = 0;
      for (r = 0; r < rows; r++) begin
         sum = '0;
         for (c = 0; c < cols; c++) begin
            entry_ext = matrix_entry[r*MAX_DIM + c];
            elem_ext  = vector_elem[c];
            sum += entry_ext * elem_ext;
         end
         // Round to nearest at 16 fraction bits, ties toward plus infinity.
         rounded = (sum + 72'sd32768) >>> mvm_pkg::FRAC_BITS;
         beat.row       = r[3:0];
         beat.mismatch  = 1'b0;
         beat.final_row = (r == rows - 1);
         if (rounded > Q_MAX) begin
            beat.product   = Q_MAX[mvm_pkg::PRODUCT_W-1:0];
            beat.saturated = 1'b1;
         end else if (rounded < Q_MIN) begin
            beat.product   = Q_MIN[mvm_pkg::PRODUCT_W-1:0];
            beat.saturated = 1'b1;
         end else begin
            beat.product   = rounded[mvm_pkg::PRODUCT_W-1:0];
            beat.saturated = 1'b0;
         end
         computed_beats.push_back(beat);
         product_beats++;
      end
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Hold off new beats until every expected result is back and the block has gone quiet.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input mvm_pkg::csr_index_type index,
                            input logic [mvm_pkg::CSR_DATA_W-1:0] value);
      wait_idle();
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         REG_ROWS: rows_reg = value;
         REG_COLS: cols_reg = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic send_item(input mvm_pkg::func_type func,
                            input logic [mvm_pkg::OPERAND_W-1:0] value,
                            input logic last, input bit typed, input rsp_beat_type want);
      int gap;
      gap = tx_burst ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   = 1'b1;
      req_bus.func    = func;
      req_bus.operand = value;
      req_bus.vec_end = last;
      do @(posedge clock); while (!req_bus.ready);
      predict_beat(func, value, last);
      if (typed) expected_beats.push_back(want);
      else foreach (computed_beats[i]) expected_beats.push_back(computed_beats[i]);
      beats_sent++;
   endtask

   // Result side: ready drops at random, with long stretches of no stalls.
   initial begin
      int  stall_left;
      bit  rx_burst;
      stall_left    = 0;
      rx_burst      = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) rx_burst = !rx_burst;
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!rx_burst) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.row_index, rsp_bus.product, rsp_bus.saturated,
                 rsp_bus.mismatch, rsp_bus.final_row};
         if (expected_beats.size() == 0) begin
            note_failure($sformatf("result beat with nothing expected: row %0d product %h",
                                   got.row, got.product));
         end else begin
            want = expected_beats.pop_front();
            if (got !== want)
               note_failure($sformatf(
                  "want row %0d prod %h sat %b err %b fin %b, got row %0d prod %h sat %b err %b fin %b",
                  want.row, want.product, want.saturated, want.mismatch, want.final_row,
                  got.row, got.product, got.saturated, got.mismatch, got.final_row));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d results outstanding", expected_beats.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int                             phase;
      int                             random_start;
      int                             rows_size;
      int                             cols_size;
      int                             run_len;
      int                             run_count;
      int                             pick;
      bit                             matrix_ready;
      logic [mvm_pkg::CSR_DATA_W-1:0] rows_val;
      logic [mvm_pkg::CSR_DATA_W-1:0] cols_val;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.func    = F_LOAD;
      req_bus.operand = '0;
      req_bus.vec_end = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = REG_ROWS;
      csr_bus.data    = '0;
      tx_burst        = 1'b0;
      fail_count      = 0;
      beats_sent      = 0;
      reg_writes      = 0;
      product_beats   = 0;
      length_errors   = 0;
      load_slot       = 0;
      elem_count      = 0;
      rows_reg        = mvm_pkg::DIM_RESET;
      cols_reg        = mvm_pkg::DIM_RESET;
      foreach (matrix_entry[i]) begin
         matrix_entry[i] = '0;
         entry_loaded[i] = 1'b0;
      end
      foreach (vector_elem[i]) vector_elem[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR)
            write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
         else
            send_item(directed_steps[i].func, directed_steps[i].operand,
                      directed_steps[i].vec_end, directed_steps[i].typed,
                      directed_steps[i].want);
      end
      wait_idle();

      // Each phase sets a shape, then runs whole vectors against it; most runs are well formed.
      phase = 0;
      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         if (phase == 0) begin
            rows_val = 5'd31;
            cols_val = 5'd1;
         end else if (phase == 1) begin
            rows_val = 5'd0;
            cols_val = 5'd16;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               rows_size = $urandom_range(1, 4);
               cols_size = $urandom_range(1, 4);
            end else if (pick < 8) begin
               rows_size = $urandom_range(5, MAX_DIM);
               cols_size = $urandom_range(1, 2);
            end else begin
               rows_size = $urandom_range(1, 2);
               cols_size = $urandom_range(5, MAX_DIM);
            end
            rows_val = encode_dim(rows_size);
            cols_val = encode_dim(cols_size);
         end
         if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_ROWS, rows_val);
            write_reg(REG_COLS, cols_val);
         end else begin
            write_reg(REG_COLS, cols_val);
            write_reg(REG_ROWS, rows_val);
         end
         rows_size = dim_of(rows_val);
         cols_size = dim_of(cols_val);
         tx_burst  = ($urandom_range(0, 4) == 0);

         run_count = $urandom_range(2, 5);
         for (int run = 0; run < run_count && beats_sent - random_start < RANDOM_BEATS;
              run++) begin
            if ($urandom_range(0, 19) == 0) wait_idle();
            if ($urandom_range(0, 99) < 75) begin
               matrix_ready = 1'b1;
               for (int r = 0; r < rows_size; r++)
                  for (int c = 0; c < cols_size; c++)
                     if (!entry_loaded[r*MAX_DIM + c]) matrix_ready = 1'b0;
               // A full set of loads covers every slot wherever the load position stands.
               if (!matrix_ready || $urandom_range(0, 1) == 1)
                  repeat (rows_size * cols_size)
                     send_item(F_LOAD, rand_operand(), 1'($urandom_range(0, 1)), 1'b0,
                               NO_BEAT);
               for (int i = 0; i < cols_size; i++)
                  send_item(F_VEC, rand_operand(), i == cols_size - 1, 1'b0, NO_BEAT);
            end else begin
               // Wrong length on purpose, now and then longer than the vector store.
               do begin
                  run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_DIM + 1, 20)
                                                       : $urandom_range(1, MAX_DIM);
               end while (run_len == cols_size);
               for (int i = 0; i < run_len; i++) begin
                  if ($urandom_range(0, 4) == 0)
                     send_item(F_LOAD, rand_operand(), 1'($urandom_range(0, 1)), 1'b0,
                               NO_BEAT);
                  send_item(F_VEC, rand_operand(), i == run_len - 1, 1'b0, NO_BEAT);
               end
            end
         end
         phase++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats over %0d shapes and %0d register writes.",
               beats_sent, phase, reg_writes);
      $display("Checked %0d row products and %0d length errors, %0d failures.",
               product_beats, length_errors, fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
